FILE: src/tps_pkg.sv
// ============================================================================
// tps_pkg
// Shared types, codes and constants of the temperature profile sequencer.
// ============================================================================
package tps_pkg;

    localparam int MAX_STEPS_DEF   = 16;
    localparam int IDX_W           = 4;
    localparam int TEMP_W          = 12;
    localparam int TIME_W          = 16;
    localparam int COUNT_W         = 5;
    localparam int SAMPLE_W        = 12;
    localparam int HYST_W          = 12;
    localparam int SCALE_W         = 11;
    localparam int SCALE_FRAC      = 10;
    localparam int TDATA_IN_W      = 72;
    localparam int TDATA_OUT_W     = 24;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 12;
    localparam logic [HYST_W-1:0]  HYST_RESET  = 12'd5;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd867;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_POLL  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_STOPPED = 2'd0,
        STATUS_RUNNING = 2'd1,
        STATUS_REACHED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BEEP_NONE    = 2'd0,
        BEEP_START   = 2'd1,
        BEEP_REACHED = 2'd2,
        BEEP_STOP    = 2'd3
    } beep_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HYSTERESIS   = 2'd0,
        CFG_SENSOR_SCALE = 2'd1,
        CFG_UNUSED2      = 2'd2,
        CFG_UNUSED3      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        cmd_t                command;
        logic [IDX_W-1:0]    entry_index;
        logic [TEMP_W-1:0]   entry_temperature;
        logic [TIME_W-1:0]   entry_time;
        logic [COUNT_W-1:0]  step_count;
        logic [SAMPLE_W-1:0] sensor_sample;
        logic [TIME_W-1:0]   timer_remaining;
    } item_t;

    typedef struct packed {
        logic                script_running;
        logic                heater_on;
        status_t             cook_status;
        logic                timer_load_valid;
        logic [TIME_W-1:0]   timer_load_value;
        beep_t               beep_event;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [TEMP_W-1:0]   temperature;
        logic [TIME_W-1:0]   hold_time;
    } tbl_wr_t;

endpackage

FILE: src/tps_table.sv
// ============================================================================
// tps_table
// Stage table: one write port, one read port with registered read data.
// Forward a write that hits the address being fetched.
// ============================================================================
module tps_table #(
    parameter int MAX_STEPS = tps_pkg::MAX_STEPS_DEF,
    parameter int AW        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
    input  logic                         clk,
    input  tps_pkg::tbl_wr_t             wr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [AW-1:0]                rd_addr,
    output logic [tps_pkg::TEMP_W-1:0]   rd_temperature,
    output logic [tps_pkg::TIME_W-1:0]   rd_time
);

    logic [tps_pkg::TEMP_W-1:0] temp_mem [MAX_STEPS];
    logic [tps_pkg::TIME_W-1:0] time_mem [MAX_STEPS];
    logic [tps_pkg::TEMP_W-1:0] rd_temp_reg;
    logic [tps_pkg::TIME_W-1:0] rd_time_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            temp_mem[wr_addr] <= wr.temperature;
            time_mem[wr_addr] <= wr.hold_time;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr_addr == rd_addr))
        begin
            rd_temp_reg <= wr.temperature;
            rd_time_reg <= wr.hold_time;
        end
        else
        begin
            rd_temp_reg <= temp_mem[rd_addr];
            rd_time_reg <= time_mem[rd_addr];
        end
    end

    assign rd_temperature = rd_temp_reg;
    assign rd_time        = rd_time_reg;

endmodule

FILE: src/tps_ctrl.sv
// ============================================================================
// tps_ctrl
// Sequencer state and the single-pass decision logic for one request:
// start, stage arming, timer reloads, thermostat and stage advance.
// ============================================================================
module tps_ctrl #(
    parameter int MAX_STEPS = tps_pkg::MAX_STEPS_DEF,
    parameter int AW        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  tps_pkg::item_t                item,
    input  logic [tps_pkg::TEMP_W-1:0]    stage_temperature,
    input  logic [tps_pkg::TIME_W-1:0]    stage_time,
    input  logic [tps_pkg::HYST_W-1:0]    hysteresis,
    input  logic [tps_pkg::SCALE_W-1:0]   sensor_scale,
    output logic [AW-1:0]                 fetch_addr,
    output tps_pkg::result_t              result
);

    localparam int PROD_W = tps_pkg::SAMPLE_W + tps_pkg::SCALE_W;
    localparam int DEG_W  = PROD_W - tps_pkg::SCALE_FRAC;
    localparam int DIFF_W = DEG_W + 1;

    logic [tps_pkg::COUNT_W-1:0] stages_left_reg, stages_left_next;
    logic [tps_pkg::COUNT_W-1:0] stages_total_reg, stages_total_next;
    logic                        running_reg, running_next;
    logic                        armed_reg, armed_next;
    logic                        seen_reg, seen_next;
    logic                        announced_reg, announced_next;
    logic                        heater_reg, heater_next;
    tps_pkg::status_t            status_reg, status_next;

    logic [PROD_W-1:0]           product;
    logic [DEG_W-1:0]            degrees;
    logic signed [DIFF_W-1:0]    shortfall;
    logic                        want_on;
    logic                        at_target;
    logic [tps_pkg::COUNT_W-1:0] count_clamped;
    logic [tps_pkg::COUNT_W-1:0] fetch_dec;
    logic [tps_pkg::TIME_W-1:0]  remaining;
    logic                        load_valid;
    logic [tps_pkg::TIME_W-1:0]  load_value;
    tps_pkg::beep_t              beep;

    assign product   = PROD_W'(item.sensor_sample) * PROD_W'(sensor_scale);
    assign degrees   = product[PROD_W-1:tps_pkg::SCALE_FRAC];
    assign shortfall = $signed(DIFF_W'(stage_temperature)) - $signed(DIFF_W'(degrees));
    assign want_on   = shortfall > $signed(DIFF_W'(hysteresis));
    assign at_target = DEG_W'(stage_temperature) <= degrees;

    always_comb
    begin
        if (item.step_count == '0)
            count_clamped = tps_pkg::COUNT_W'(1);
        else if (int'(item.step_count) > MAX_STEPS)
            count_clamped = tps_pkg::COUNT_W'(MAX_STEPS);
        else
            count_clamped = item.step_count;
    end

    always_comb
    begin
        stages_left_next  = stages_left_reg;
        stages_total_next = stages_total_reg;
        running_next      = running_reg;
        armed_next        = armed_reg;
        seen_next         = seen_reg;
        announced_next    = announced_reg;
        heater_next       = heater_reg;
        status_next       = status_reg;
        load_valid        = 1'b0;
        load_value        = '0;
        beep              = tps_pkg::BEEP_NONE;
        remaining         = item.timer_remaining;

        if (fire)
        begin
            unique case (item.command)
                tps_pkg::CMD_LOAD, tps_pkg::CMD_NONE:
                begin
                end
                tps_pkg::CMD_START:
                begin
                    stages_left_next  = count_clamped;
                    stages_total_next = count_clamped;
                    running_next      = 1'b1;
                    seen_next         = 1'b0;
                    announced_next    = 1'b0;
                    status_next       = tps_pkg::STATUS_RUNNING;
                    beep              = tps_pkg::BEEP_START;
                end
                tps_pkg::CMD_POLL:
                begin
                    if (running_reg && !armed_reg)
                    begin
                        load_valid = 1'b1;
                        load_value = stage_time;
                        armed_next = 1'b1;
                    end
                    else if (running_reg)
                    begin
                        if ((stages_left_reg == stages_total_reg) && !seen_reg)
                        begin
                            load_valid = 1'b1;
                            load_value = stage_time;
                            remaining  = stage_time;
                        end
                        if (remaining != '0)
                        begin
                            if (stage_temperature == '0)
                                heater_next = 1'b0;
                            else if (want_on)
                                heater_next = 1'b1;
                            else if (at_target)
                            begin
                                heater_next = 1'b0;
                                seen_next   = 1'b1;
                                if (!announced_reg)
                                begin
                                    beep           = tps_pkg::BEEP_REACHED;
                                    status_next    = tps_pkg::STATUS_REACHED;
                                    announced_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            heater_next = 1'b0;
                            armed_next  = 1'b0;
                            if (stages_left_reg > tps_pkg::COUNT_W'(1))
                                stages_left_next = stages_left_reg - tps_pkg::COUNT_W'(1);
                            else
                            begin
                                running_next = 1'b0;
                                status_next  = tps_pkg::STATUS_STOPPED;
                                beep         = tps_pkg::BEEP_STOP;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        fetch_dec = (stages_left_next == '0) ? '0
                                             : stages_left_next - tps_pkg::COUNT_W'(1);
        if (int'(fetch_dec) >= MAX_STEPS)
            fetch_addr = AW'(MAX_STEPS - 1);
        else
            fetch_addr = AW'(fetch_dec);
    end

    always_comb
    begin
        result.script_running   = running_next;
        result.heater_on        = heater_next;
        result.cook_status      = status_next;
        result.timer_load_valid = load_valid;
        result.timer_load_value = load_value;
        result.beep_event       = beep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stages_left_reg  <= '0;
            stages_total_reg <= '0;
            running_reg      <= 1'b0;
            armed_reg        <= 1'b0;
            seen_reg         <= 1'b0;
            announced_reg    <= 1'b0;
            heater_reg       <= 1'b0;
            status_reg       <= tps_pkg::STATUS_STOPPED;
        end
        else
        begin
            stages_left_reg  <= stages_left_next;
            stages_total_reg <= stages_total_next;
            running_reg      <= running_next;
            armed_reg        <= armed_next;
            seen_reg         <= seen_next;
            announced_reg    <= announced_next;
            heater_reg       <= heater_next;
            status_reg       <= status_next;
        end
    end

    a_status_tracks_running: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg == (status_reg != tps_pkg::STATUS_STOPPED))
        else $error("status and running flag disagree");

    a_stage_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (stages_left_reg != '0) && (stages_left_reg <= stages_total_reg))
        else $error("stage count out of range while running");

    a_announce_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        announced_reg |-> seen_reg)
        else $error("target announced without being seen");

    a_heater_off_when_ended: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> !heater_reg)
        else $error("heater on after profile ended");

endmodule

FILE: src/temperature_profile_sequencer.sv
// ============================================================================
// temperature_profile_sequencer
// Top level: stream channels, configuration registers, request and result
// registers around the stage table and the sequencer logic.
// ============================================================================
// Usage:
//   s_axis carries requests: s_tuser is the command (load, start, poll),
//   s_tdata the entry, step count, sensor sample and timer count.
//   m_axis returns exactly one result per request, in order. The cfg channel
//   writes hysteresis (index 0) and sensor_scale (index 1); the user must
//   do so only with no request in flight (unchecked); cfg_ready is always high.
// Timing:
//   A request is taken into an input register, decided combinationally
//   and its result is registered into the output register behind m_axis.
//   One request per cycle is sustained while m_tready stays high; the stage
//   table read is prefetched for the next stage through a registered read
//   port, so a poll right after a start or a load sees the updated entry.
// Reset and stall:
//   rst_n clears the profile state (ended, heater off, status stopped) and
//   sets the registers to their defaults; the stage table is not cleared.
//   When m_tready is low the result holds, one more request is buffered and
//   then s_tready drops until the result is taken.
// ============================================================================
module temperature_profile_sequencer #(
    parameter int MAX_STEPS = tps_pkg::MAX_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[3:0], entry_temperature[15:4], entry_time[31:16],
    // step_count[36:32], sensor_sample[48:37], timer_remaining[64:49]
    input  logic [tps_pkg::TDATA_IN_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // script_running[0], heater_on[1], cook_status[3:2], timer_load_valid[4],
    // timer_load_value[20:5], beep_event[22:21]
    output logic [tps_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic                          in_valid_reg;
    tps_pkg::item_t                in_item_reg;
    logic                          out_valid_reg;
    tps_pkg::result_t              out_result_reg;
    logic [tps_pkg::HYST_W-1:0]    hyst_reg;
    logic [tps_pkg::SCALE_W-1:0]   scale_reg;

    tps_pkg::item_t                s_item;
    logic                          fire;
    tps_pkg::result_t              result;
    tps_pkg::tbl_wr_t              tbl_wr;
    logic [AW-1:0]                 tbl_wr_addr;
    logic [AW-1:0]                 fetch_addr;
    logic [tps_pkg::TEMP_W-1:0]    cur_temperature;
    logic [tps_pkg::TIME_W-1:0]    cur_time;

    always_comb
    begin
        s_item.command           = tps_pkg::cmd_t'(s_tuser);
        s_item.entry_index       = s_tdata[3:0];
        s_item.entry_temperature = s_tdata[15:4];
        s_item.entry_time        = s_tdata[31:16];
        s_item.step_count        = s_tdata[36:32];
        s_item.sensor_sample     = s_tdata[48:37];
        s_item.timer_remaining   = s_tdata[64:49];
    end

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= s_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_result_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg  <= tps_pkg::HYST_RESET;
            scale_reg <= tps_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (tps_pkg::cfg_index_t'(cfg_index))
                tps_pkg::CFG_HYSTERESIS:   hyst_reg  <= cfg_data[tps_pkg::HYST_W-1:0];
                tps_pkg::CFG_SENSOR_SCALE: scale_reg <= cfg_data[tps_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        tbl_wr.en          = fire && (in_item_reg.command == tps_pkg::CMD_LOAD)
                             && (int'(in_item_reg.entry_index) < MAX_STEPS);
        tbl_wr.temperature = in_item_reg.entry_temperature;
        tbl_wr.hold_time   = in_item_reg.entry_time;
        tbl_wr_addr        = AW'(in_item_reg.entry_index);
    end

    tps_table #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_table (
        .clk            (clk),
        .wr             (tbl_wr),
        .wr_addr        (tbl_wr_addr),
        .rd_addr        (fetch_addr),
        .rd_temperature (cur_temperature),
        .rd_time        (cur_time)
    );

    tps_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .item              (in_item_reg),
        .stage_temperature (cur_temperature),
        .stage_time        (cur_time),
        .hysteresis        (hyst_reg),
        .sensor_scale      (scale_reg),
        .fetch_addr        (fetch_addr),
        .result            (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.beep_event,
                       out_result_reg.timer_load_value,
                       out_result_reg.timer_load_valid,
                       out_result_reg.cook_status,
                       out_result_reg.heater_on,
                       out_result_reg.script_running};

endmodule
